>>> rtl/mtgl_pkg.sv
// shared types and constants for the multibyte text glyph locator
`timescale 1ns / 1ps
`default_nettype none

package mtgl_pkg;

  localparam logic [1:0] MODE_ASCII = 2'd0;
  localparam logic [1:0] MODE_SJIS  = 2'd1;
  localparam logic [1:0] MODE_EUC   = 2'd2;
  localparam logic [1:0] MODE_LARGE = 2'd3;

  localparam logic [11:0] PEN_MAX  = 12'd4095;
  localparam logic [12:0] PEN_STEP = 13'd8;

  localparam logic [21:0] NAT_BASE = 22'd4096;
  localparam logic [21:0] ROW_LEN  = 22'd94;
  localparam logic [19:0] HALF_OFS = 20'd16;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [1:0] {
    REQ_SINGLE,
    REQ_PAIR,
    REQ_LARGE
  } req_t;

  typedef struct packed {
    req_t       req;
    logic [1:0] mode;
    logic [7:0] code;
    logic [7:0] lead;
    logic [11:0] pen;
  } item_t;

  typedef struct packed {
    logic [12:0] x;
    logic        table_sel;
    logic [19:0] offset;
    logic        kind;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/mtgl_decode.sv
// input stage: lead byte and pen tracking, request classification
`timescale 1ns / 1ps
`default_nettype none

module mtgl_decode
  import mtgl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wen,
  input  wire logic [1:0]           cfg_wdata,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  input  wire logic                 in_tuser,
  output logic                      item_valid,
  output item_t                     item,
  input  wire logic                 item_ready
);

  logic [1:0]  mode_r;
  logic [7:0]  lead_r;
  logic [11:0] pen_r;
  logic        s1_v_r;
  item_t       item_r;

  logic [7:0]  code;
  logic [11:0] px;
  logic [12:0] px_sum;
  logic [11:0] pen_nxt;
  logic [7:0]  lead_nxt;
  logic        is_lead;
  logic        emit;
  req_t        req;
  logic        accept;

  assign code   = in_tdata[7:0];
  assign px     = in_tuser ? in_tdata[19:8] : pen_r;
  assign px_sum = {1'b0, px} + PEN_STEP;
  assign pen_nxt = px_sum[12] ? PEN_MAX : px_sum[11:0];

  always_comb begin
    case (mode_r)
      MODE_SJIS:  is_lead = code inside {[8'h81:8'h9f], [8'he0:8'hfc]};
      MODE_EUC:   is_lead = code inside {[8'h81:8'hfe]};
      MODE_LARGE: is_lead = code inside {[8'ha1:8'hfe]};
      default:    is_lead = 1'b0;
    endcase
  end

  always_comb begin
    req      = REQ_SINGLE;
    emit     = 1'b1;
    lead_nxt = lead_r;
    if (mode_r == MODE_ASCII) begin
      req = REQ_SINGLE;
    end else if (lead_r == 8'd0) begin
      if (is_lead) begin
        emit     = 1'b0;
        lead_nxt = code;
      end
    end else begin
      lead_nxt = 8'd0;
      req      = (mode_r == MODE_LARGE) ? REQ_LARGE : REQ_PAIR;
    end
  end

  assign in_tready  = !s1_v_r || item_ready;
  assign accept     = in_tvalid && in_tready;
  assign item_valid = s1_v_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ASCII;
      lead_r <= 8'd0;
      pen_r  <= 12'd0;
      s1_v_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        mode_r <= cfg_wdata;
      end
      if (accept) begin
        lead_r <= lead_nxt;
        pen_r  <= pen_nxt;
        s1_v_r <= emit;
      end else if (item_ready) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.req  <= req;
      item_r.mode <= mode_r;
      item_r.code <= code;
      item_r.lead <= lead_r;
      item_r.pen  <= px;
    end
  end

`ifndef SYNTHESIS
  a_lead_high: assert property (@(posedge clk) disable iff (!rst_n)
    lead_r != 8'd0 |-> lead_r[7])
    else $error("pending lead below 0x80");

  a_pen_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_tuser && pen_r < 12'd4088 |=> pen_r == $past(pen_r) + 12'd8)
    else $error("pen did not advance by one cell");

  a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !item_ready |=> s1_v_r)
    else $error("stalled item dropped");
`endif

endmodule

`default_nettype wire

>>> rtl/mtgl_emit.sv
// offset arithmetic and two-entry result register feeding the output channel
`timescale 1ns / 1ps
`default_nettype none

module mtgl_emit
  import mtgl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  item_valid,
  input  item_t                      item,
  output logic                       item_ready,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [1:0]                 out_tuser,
  output logic                       out_tlast
);

  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  res_t       slot0_r;
  res_t       slot1_r;

  logic [9:0]  k;
  logic [9:0]  t;
  logic [9:0]  lead10;
  logic [9:0]  code10;
  logic [21:0] idx;
  logic [21:0] off;
  logic [12:0] x_here;
  logic [12:0] x_prev;
  res_t        r0;
  res_t        r1;
  logic        load;
  logic        out_hs;

  assign lead10 = {2'b00, item.lead};
  assign code10 = {2'b00, item.code};

  always_comb begin
    if (item.mode == MODE_SJIS) begin
      if (item.lead inside {[8'h81:8'h9f]}) begin
        k = (lead10 - 10'h081) << 1;
      end else begin
        k = ((lead10 - 10'h0e0) << 1) + 10'd62;
      end
      if (item.code inside {[8'h40:8'h7e]}) begin
        t = code10 - 10'h040;
      end else if (item.code inside {[8'h80:8'h9e]}) begin
        t = code10 - 10'h080 + 10'd63;
      end else begin
        t = code10 - 10'h09f;
        k = k + 10'd1;
      end
    end else begin
      k = lead10 - 10'h0a1;
      t = code10 - 10'h0a1;
    end
  end

  assign idx    = {{12{k[9]}}, k} * ROW_LEN + {{12{t[9]}}, t};
  assign off    = (idx << 5) + ((item.req == REQ_PAIR) ? NAT_BASE : 22'd0);
  assign x_here = {1'b0, item.pen};
  assign x_prev = x_here - PEN_STEP;

  always_comb begin
    r0      = '0;
    r1      = '0;
    cnt_nxt = 2'd1;
    case (item.req)
      REQ_PAIR: begin
        r0 = '{x: x_prev, table_sel: 1'b1, offset: off[19:0], kind: 1'b0, last: 1'b0};
        r1 = '{x: x_here, table_sel: 1'b1, offset: off[19:0] + HALF_OFS,
               kind: 1'b0, last: 1'b1};
        cnt_nxt = 2'd2;
      end
      REQ_LARGE: begin
        r0 = '{x: x_prev, table_sel: 1'b1, offset: off[19:0], kind: 1'b1, last: 1'b1};
      end
      default: begin
        r0 = '{x: x_here,
               table_sel: (item.mode == MODE_SJIS) || (item.mode == MODE_EUC),
               offset: {8'd0, item.code, 4'd0}, kind: 1'b0, last: 1'b1};
      end
    endcase
  end

  assign out_tvalid = cnt_r != 2'd0;
  assign out_hs     = out_tvalid && out_tready;
  assign item_ready = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_tready);
  assign load       = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= cnt_nxt;
    end else if (out_hs) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0_r <= r0;
      slot1_r <= r1;
    end else if (out_hs) begin
      slot0_r <= slot1_r;
    end
  end

  assign out_tdata = {7'd0, slot0_r.offset, slot0_r.x};
  assign out_tuser = {slot0_r.kind, slot0_r.table_sel};
  assign out_tlast = slot0_r.last;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result count out of range");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !slot0_r.last && slot1_r.last)
    else $error("pair held with wrong last marking");

  a_large_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast && out_tuser[0])
    else $error("large glyph not single national beat");
`endif

endmodule

`default_nettype wire

>>> rtl/multibyte_text_glyph_locator.sv
// Path: an accepted byte is registered in the decode item register, then loaded into the emit
//   result slots, from which its first result beat is offered; a stalled emit stage holds it back.
// Throughput: one byte per cycle while out_tready stays high, when it makes at most one result; a
//   byte that makes two results holds the single output channel until both its beats are taken.
// Lead bytes make no result.
// Reset (rst_n low, synchronous) clears lang mode to ascii, the pending lead,
//   the pen x and all pipeline valid flags.
`timescale 1ns / 1ps
`default_nettype none

module multibyte_text_glyph_locator
  import mtgl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wen,
  input  wire logic [1:0]            cfg_wdata,  // lang_mode
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // code_byte[7:0], start_x[19:8], zero pad
  input  wire logic                  in_tuser,   // new_string
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // glyph_x[12:0], glyph_offset[32:13], zero pad
  output logic [1:0]                 out_tuser,  // font_table[0], glyph_kind[1]
  output logic                       out_tlast   // last
);

  logic  item_valid;
  logic  item_ready;
  item_t item;

  mtgl_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready)
  );

  mtgl_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
